@@ hdl/rsm_pkg.sv @@
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types, constants and codes of the residual stagnation monitor.
// ----------------------------------------------------------------------------
package rsm_pkg;

  // Field widths.
  localparam int unsigned NORM_W  = 32;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned STILL_OUT_W = 4;

  // Averaging and stagnation spans.
  localparam int unsigned AVG_SPAN   = 6;
  localparam int unsigned STALL_SPAN = 10;

  // Derived sizes.
  localparam int unsigned SUM_W     = NORM_W + $clog2(AVG_SPAN);
  localparam int unsigned REM_W     = $clog2(AVG_SPAN);
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned DIV_STEPS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned DIV_W     = DIV_STEPS * DIGIT_W;
  localparam int unsigned LIM_W     = NORM_W + RATIO_W;
  localparam int unsigned CNT_MAX   = AVG_SPAN + STALL_SPAN;
  localparam int unsigned CNT_W     = $clog2(CNT_MAX + 1);
  localparam int unsigned STILL_W   = $clog2(STALL_SPAN + 1);
  localparam int unsigned IDX_W     = $clog2(STALL_SPAN);
  localparam int unsigned STEP_MAX  = (DIV_STEPS > STALL_SPAN) ? DIV_STEPS : STALL_SPAN;
  localparam int unsigned STEP_W    = $clog2(STEP_MAX);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_TOLERANCE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGNATION_RATIO = 1'd1;
  localparam logic [RATIO_W-1:0]   RATIO_RESET          = 16'd655;

  typedef enum logic [1:0] {
    STAT_CONTINUE  = 2'd0,
    STAT_CONVERGED = 2'd1,
    STAT_NAN       = 2'd2,
    STAT_STAGNATED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DECIDE,
    FSM_ADD,
    FSM_DIV,
    FSM_LIMIT,
    FSM_CMP,
    FSM_PUSH,
    FSM_FINISH
  } fsm_state_e;

  typedef struct packed {
    logic [NORM_W-1:0] norm_value;
    logic              norm_is_nan;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [NORM_W-1:0]      running_average;
    logic [STILL_OUT_W-1:0] still_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             decide;
    logic             add;
    logic             div_step;
    logic             limit;
    logic             cmp_step;
    logic [IDX_W-1:0] cmp_idx;
    logic             push;
    logic             finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic terminal;
    logic has_avg;
    logic stag_eligible;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hdl/rsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsm_ctrl
// Sequencer that walks one norm through capture, averaging and comparison.
// ----------------------------------------------------------------------------
module rsm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rsm_pkg::dp_sts_t sts_i,
  output rsm_pkg::dp_cmd_t cmd_o
);
  import rsm_pkg::*;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] CMP_LAST = STEP_W'(STALL_SPAN - 1);

  fsm_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and step counter.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = FSM_DECIDE;
        end
      end
      FSM_DECIDE: begin
        state_d = sts_i.terminal ? FSM_FINISH : FSM_ADD;
      end
      FSM_ADD: begin
        step_d  = '0;
        state_d = sts_i.has_avg ? FSM_DIV : FSM_FINISH;
      end
      FSM_DIV: begin
        if (step_q == DIV_LAST) begin
          step_d  = '0;
          state_d = sts_i.stag_eligible ? FSM_LIMIT : FSM_PUSH;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      FSM_LIMIT: begin
        step_d  = '0;
        state_d = FSM_CMP;
      end
      FSM_CMP: begin
        if (step_q == CMP_LAST) begin
          state_d = FSM_PUSH;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      FSM_PUSH: begin
        state_d = FSM_FINISH;
      end
      FSM_FINISH: begin
        if (sts_i.out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o         = '0;
    cmd_o.cmp_idx = step_q[IDX_W-1:0];
    in_stall_o    = 1'b1;
    unique case (state_q)
      FSM_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      FSM_DECIDE: cmd_o.decide   = 1'b1;
      FSM_ADD:    cmd_o.add      = 1'b1;
      FSM_DIV:    cmd_o.div_step = 1'b1;
      FSM_LIMIT:  cmd_o.limit    = 1'b1;
      FSM_CMP:    cmd_o.cmp_step = 1'b1;
      FSM_PUSH:   cmd_o.push     = 1'b1;
      FSM_FINISH: cmd_o.finish   = sts_i.out_free;
      default:    cmd_o          = '0;
    endcase
  end

endmodule

@@ hdl/rsm_datapath.sv @@
// ----------------------------------------------------------------------------
// rsm_datapath
// Norm window, running sum, digit divider, average history and result register.
// ----------------------------------------------------------------------------
module rsm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rsm_pkg::in_item_t                 in_item_i,
  input  logic                              cfg_we_i,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rsm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  rsm_pkg::dp_cmd_t                  cmd_i,
  output rsm_pkg::dp_sts_t                  sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rsm_pkg::out_item_t                out_item_o
);
  import rsm_pkg::*;

  // Configuration registers.
  logic [NORM_W-1:0]  tol_q;
  logic [RATIO_W-1:0] ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= '0;
      ratio_q <= RATIO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ABS_TOLERANCE:    tol_q   <= cfg_data_i[NORM_W-1:0];
        CFG_STAGNATION_RATIO: ratio_q <= cfg_data_i[RATIO_W-1:0];
        default:              tol_q   <= tol_q;
      endcase
    end
  end

  // Captured transaction.
  logic [NORM_W-1:0] norm_q;
  logic              nan_q;
  logic              restart_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      norm_q    <= in_item_i.norm_value;
      nan_q     <= in_item_i.norm_is_nan;
      restart_q <= in_item_i.restart;
    end
  end

  logic terminal;
  assign terminal = nan_q || (norm_q <= tol_q);

  // Iteration count, window and running sum of the window.
  logic [CNT_W-1:0]  count_q;
  logic [NORM_W-1:0] win_q [AVG_SPAN];
  logic [SUM_W-1:0]  sum_q;
  logic              term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      term_q  <= 1'b0;
      for (int k = 0; k < AVG_SPAN; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      if (cmd_i.decide) begin
        term_q <= terminal;
        if (restart_q) begin
          count_q <= '0;
        end
        if (!terminal) begin
          sum_q <= sum_q - SUM_W'(win_q[AVG_SPAN-1]);
          for (int k = AVG_SPAN - 1; k > 0; k--) begin
            win_q[k] <= win_q[k-1];
          end
          win_q[0] <= norm_q;
        end
      end
      if (cmd_i.add) begin
        sum_q <= sum_q + SUM_W'(norm_q);
      end
      if (cmd_i.finish && !term_q && (count_q < CNT_W'(CNT_MAX))) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Division of the sum by the span, one byte of dividend per cycle.
  logic [DIV_W-1:0]   div_work_q;
  logic [REM_W-1:0]   rem_q;
  logic [NORM_W-1:0]  avg_q;
  logic [REM_W-1:0]   rem_next;
  logic [DIGIT_W-1:0] q_digit;

  always_comb begin
    logic [REM_W:0]     trial;
    logic [DIGIT_W-1:0] digit;
    digit    = div_work_q[DIV_W-1 -: DIGIT_W];
    rem_next = rem_q;
    q_digit  = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      trial = {rem_next, digit[b]};
      if (trial >= (REM_W+1)'(AVG_SPAN)) begin
        trial      = trial - (REM_W+1)'(AVG_SPAN);
        q_digit[b] = 1'b1;
      end
      rem_next = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      avg_q <= '0;
    end
    if (cmd_i.add) begin
      div_work_q <= DIV_W'(sum_q + SUM_W'(norm_q));
      rem_q      <= '0;
    end
    if (cmd_i.div_step) begin
      div_work_q <= div_work_q << DIGIT_W;
      rem_q      <= rem_next;
      avg_q      <= NORM_W'({avg_q, q_digit});
    end
  end

  // Ratio limit and sequential comparison against the history.
  logic [LIM_W-1:0]   limit_q;
  logic [STILL_W-1:0] still_q;
  logic [NORM_W-1:0]  hist_q [STALL_SPAN];
  logic [NORM_W-1:0]  hist_sel;
  logic [NORM_W-1:0]  diff;
  logic               is_close;

  assign hist_sel = hist_q[cmd_i.cmp_idx];
  assign diff     = (hist_sel >= avg_q) ? (hist_sel - avg_q) : (avg_q - hist_sel);
  assign is_close = ({diff, {RATIO_W{1'b0}}} < limit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      still_q <= '0;
    end
    if (cmd_i.limit) begin
      limit_q <= LIM_W'(ratio_q) * LIM_W'(avg_q);
    end
    if (cmd_i.cmp_step) begin
      still_q <= still_q + STILL_W'(is_close);
    end
    if (cmd_i.push) begin
      for (int k = STALL_SPAN - 1; k > 0; k--) begin
        hist_q[k] <= hist_q[k-1];
      end
      hist_q[0] <= avg_q;
    end
  end

  // Result register.
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      out_free;
  status_e   res_status;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    priority if (term_q) begin
      res_status = nan_q ? STAT_NAN : STAT_CONVERGED;
    end else if (still_q == STILL_W'(STALL_SPAN)) begin
      res_status = STAT_STAGNATED;
    end else begin
      res_status = STAT_CONTINUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_item_q.status          <= res_status;
      out_item_q.running_average <= avg_q;
      out_item_q.still_count     <= STILL_OUT_W'(still_q);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_item_q;
  assign sts_o.terminal      = terminal;
  assign sts_o.has_avg       = (count_q >= CNT_W'(AVG_SPAN));
  assign sts_o.stag_eligible = (count_q >= CNT_W'(CNT_MAX));
  assign sts_o.out_free      = out_free;

endmodule

@@ hdl/residual_stagnation_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// residual_stagnation_monitor_unit
// Per-iteration residual monitor: convergence, NaN and stagnation status.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Contents
//   --------+-----------+----------------------+---------------------------------
//   in      | in        | in_valid_i/in_stall_o| norm, NaN flag, restart flag
//   out     | out       | out_valid_o/out_stall_i | status, average, still count
//   cfg     | in        | cfg_valid_i/cfg_ready_o | register index and data
//
// A norm that ends the solve (NaN or at or below the tolerance) goes from
// the decision straight to the result load. A norm before the seventh
// iteration only adds to the running sum, one with an average also runs
// the byte-wise divider, and from the seventeenth iteration on the ratio
// limit is formed and the shared comparator walks the ten stored averages.
// The next transaction is accepted in the cycle after the result loads.
// Reset clears the iteration count, norm window, running sum and ratio to
// their defaults; the average history needs no clearing because it is always
// written before it is read. A stalled result holds in the output register
// while the next transaction is already accepted and processed; only the
// final load waits for the register to free up.
//
module residual_stagnation_monitor_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rsm_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rsm_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rsm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rsm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration writes are always taken; software must write only when idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  // The controller sequences each transaction through the datapath steps.
  rsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the window, the divider, the history and the result.
  rsm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ hdl/rsm_checker.sv @@
// ----------------------------------------------------------------------------
// rsm_checker
// Port-level checks of the residual stagnation monitor, bound to the top.
// ----------------------------------------------------------------------------
module rsm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input rsm_pkg::out_item_t             out_item_o
);
  import rsm_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  // One transaction at a time: after an accept the input is stalled.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while busy");

  // Stagnation means every stored average was within the ratio.
  a_stag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STAT_STAGNATED) |->
      (out_item_o.still_count == STILL_OUT_W'(STALL_SPAN)))
    else $error("stagnation without full still count");

  // A terminal result carries no average and no comparisons.
  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.status == STAT_CONVERGED) ||
                    (out_item_o.status == STAT_NAN)) |->
      (out_item_o.running_average == '0) && (out_item_o.still_count == '0))
    else $error("terminal result with average or count");

  // The still count never exceeds the number of stored averages.
  a_still_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.still_count <= STILL_OUT_W'(STALL_SPAN)))
    else $error("still count out of range");

endmodule

bind residual_stagnation_monitor_unit rsm_checker u_rsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
